// ===== rtl/pdpc_pkg.sv =====
// ----------------------------------------------------------------------------
// PD position controller package
// Widths, register indexes, reset values and item codes shared by the block.
// ----------------------------------------------------------------------------
package pdpc_pkg;

  // fractional bits of the Q gains
  localparam int unsigned GAIN_FRAC_BITS = 16;

  localparam int unsigned POS_W      = 32;
  localparam int unsigned ERR_W      = POS_W + 1;
  localparam int unsigned DIFF_W     = ERR_W + 1;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned LIM_W      = 8;
  localparam int unsigned PROD_P_W   = GAIN_W + 1 + ERR_W;
  localparam int unsigned PROD_D_W   = GAIN_W + 1 + DIFF_W;
  localparam int unsigned SUM_W      = PROD_D_W + 1;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = GAIN_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP_GAIN     = 2'd0,
    REG_KD_GAIN     = 2'd1,
    REG_DRIVE_LIMIT = 2'd2
  } reg_idx_e;

  localparam logic [GAIN_W-1:0] KP_GAIN_RST     = 16'd16266;
  localparam logic [GAIN_W-1:0] KD_GAIN_RST     = 16'd8133;
  localparam logic [LIM_W-1:0]  DRIVE_LIMIT_RST = 8'd255;

  // item kinds
  localparam logic FUNC_EDGE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

endpackage

// ===== rtl/pdpc_stream_if.sv =====
// ----------------------------------------------------------------------------
// PD position controller stream interfaces
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface pdpc_in_if import pdpc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    func;
  logic                    channel_b_level;
  logic signed [POS_W-1:0] target_count;

  modport source (output valid, func, channel_b_level, target_count, input ready);
  modport sink   (input valid, func, channel_b_level, target_count, output ready);
endinterface

interface pdpc_out_if import pdpc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    direction;
  logic [LIM_W-1:0]        pwm_duty;
  logic signed [POS_W-1:0] position_now;
  logic signed [ERR_W-1:0] error_now;

  modport source (output valid, direction, pwm_duty, position_now, error_now, input ready);
  modport sink   (input valid, direction, pwm_duty, position_now, error_now, output ready);
endinterface

// ===== rtl/encoder_pd_position_controller_top.sv =====
// ----------------------------------------------------------------------------
// Encoder PD position controller
// Counts encoder edges and turns each control tick into a saturated PWM drive.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one word per event. func = FUNC_EDGE is a rising edge on
//   encoder channel A; channel_b_level picks the count direction (high: down,
//   low: up). Edge words give no result. func = FUNC_TICK carries a target
//   position; it gives exactly one result word on out_o with direction, PWM
//   duty, the position at the tick and the position error.
//   Gains and the drive limit are written through cfg_we_i / cfg_idx_i /
//   cfg_data_i while no tick is in flight; unknown indexes are dropped.
// Pipeline and throughput:
//   An accepted tick is registered in the error stage, then in the
//   multiplier stage, then the sum/saturate stage loads the output register.
//   One word is taken every cycle, edges and ticks alike, while in_i.ready
//   is high.
// Reset:
//   rst_ni clears the position count, the previous error and all valid bits
//   and loads the default gains and drive limit.
// Stall:
//   When out_o.ready is low the result word holds and the stages behind it
//   keep filling; in_i.ready falls only once all three stages hold a tick.
// ----------------------------------------------------------------------------
module encoder_pd_position_controller_top import pdpc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  pdpc_in_if.sink               in_i,
  pdpc_out_if.source            out_o
);

  // configuration
  logic [GAIN_W-1:0] kp_q;
  logic [GAIN_W-1:0] kd_q;
  logic [LIM_W-1:0]  limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q    <= KP_GAIN_RST;
      kd_q    <= KD_GAIN_RST;
      limit_q <= DRIVE_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_KP_GAIN:     kp_q    <= cfg_data_i;
        REG_KD_GAIN:     kd_q    <= cfg_data_i;
        REG_DRIVE_LIMIT: limit_q <= cfg_data_i[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake: each stage moves when the next one has room
  logic v1_q, v2_q, out_valid_q;
  logic rdy1, rdy2, rdy3;
  logic in_accept, tick_acc, edge_acc;

  assign rdy3      = !out_valid_q || out_o.ready;
  assign rdy2      = !v2_q || rdy3;
  assign rdy1      = !v1_q || rdy2;
  assign in_i.ready = rdy1;

  assign in_accept = in_i.valid && rdy1;
  assign tick_acc  = in_accept && (in_i.func == FUNC_TICK);
  assign edge_acc  = in_accept && (in_i.func == FUNC_EDGE);

  // position count and previous error
  logic signed [POS_W-1:0] pos_q;
  logic signed [ERR_W-1:0] prev_err_q;
  logic signed [ERR_W-1:0] err_d;
  logic signed [DIFF_W-1:0] diff_d;

  // error against the count as it stands before this cycle's update
  assign err_d  = ERR_W'(in_i.target_count) - ERR_W'(pos_q);
  assign diff_d = DIFF_W'(err_d) - DIFF_W'(prev_err_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      prev_err_q <= '0;
    end else begin
      if (edge_acc) begin
        // down on channel B high, up on low; wrap on overflow
        pos_q <= in_i.channel_b_level ? pos_q - POS_W'(1) : pos_q + POS_W'(1);
      end
      if (tick_acc) begin
        prev_err_q <= err_d;
      end
    end
  end

  // stage 1: error and error change
  logic signed [POS_W-1:0]  pos1_q;
  logic signed [ERR_W-1:0]  err1_q;
  logic signed [DIFF_W-1:0] diff1_q;

  // stage 2: gain products
  logic signed [POS_W-1:0]    pos2_q;
  logic signed [ERR_W-1:0]    err2_q;
  logic signed [PROD_P_W-1:0] prodp_q;
  logic signed [PROD_D_W-1:0] prodd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= tick_acc;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_acc) begin
      pos1_q  <= pos_q;
      err1_q  <= err_d;
      diff1_q <= diff_d;
    end
    if (rdy2 && v1_q) begin
      pos2_q  <= pos1_q;
      err2_q  <= err1_q;
      prodp_q <= $signed({1'b0, kp_q}) * err1_q;
      prodd_q <= $signed({1'b0, kd_q}) * diff1_q;
    end
  end

  // stage 3: sum, magnitude, scale and saturate
  logic signed [SUM_W-1:0] sum_c;
  logic                    neg_c;
  logic [SUM_W-1:0]        mag_c;
  logic [SUM_W-1:0]        mag_sh_c;
  logic [LIM_W-1:0]        duty_c;
  logic                    dir_c;

  always_comb begin
    sum_c    = SUM_W'(prodp_q) + SUM_W'(prodd_q);
    neg_c    = sum_c[SUM_W-1];
    // magnitude then shift gives rounding toward zero
    mag_c    = neg_c ? SUM_W'(-sum_c) : SUM_W'(sum_c);
    mag_sh_c = mag_c >> GAIN_FRAC_BITS;
    duty_c   = (mag_sh_c > SUM_W'(limit_q)) ? limit_q : mag_sh_c[LIM_W-1:0];
    // a drive that ends at zero points forward
    dir_c    = neg_c && (duty_c != '0);
  end

  logic                    dir_q;
  logic [LIM_W-1:0]        duty_q;
  logic signed [POS_W-1:0] pos3_q;
  logic signed [ERR_W-1:0] err3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rdy3) begin
      out_valid_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      dir_q  <= dir_c;
      duty_q <= duty_c;
      pos3_q <= pos2_q;
      err3_q <= err2_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.direction    = dir_q;
  assign out_o.pwm_duty     = duty_q;
  assign out_o.position_now = pos3_q;
  assign out_o.error_now    = err3_q;

  // checks
  a_edge_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    edge_acc && !in_i.channel_b_level |=> pos_q == $past(pos_q) + POS_W'(1))
    else $error("position did not advance on an up edge");

  a_prev_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_acc |=> prev_err_q == err1_q)
    else $error("previous error out of step with stage 1");

  a_duty_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> duty_q <= limit_q)
    else $error("duty above drive limit");

  a_dir_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && dir_q |-> duty_q != '0)
    else $error("negative direction with zero duty");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rdy1 |-> v1_q && v2_q && out_valid_q && !out_o.ready)
    else $error("input stalled with room in the pipeline");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder PD position controller testbench
// Feeds edge and tick words through the input channel while a local predictor
// tracks the position count, the previous error and the gain registers. Every
// result word is checked field by field against the oldest prediction. Gains
// and drive limit are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
  import pdpc_pkg::*;

  // index that maps to no register: writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_IDX = 2'd3;
  // cycles without any handshake before the run is abandoned
  localparam int unsigned QUIET_LIMIT = 4000;
  // pipeline depth plus margin, waited out before touching the registers
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned PHASE_WORDS = 265;

  typedef struct {
    logic                    func;
    logic                    channel_b_level;
    logic signed [POS_W-1:0] target_count;
  } enc_word_t;

  typedef struct {
    logic                    direction;
    logic [LIM_W-1:0]        pwm_duty;
    logic signed [POS_W-1:0] position_now;
    logic signed [ERR_W-1:0] error_now;
  } drive_t;

  // receiver back-pressure styles
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_LIGHT,
    RX_HALF,
    RX_HEAVY
  } rx_mode_e;

  logic                  clk_i;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  pdpc_in_if  in_if ();
  pdpc_out_if out_if ();

  encoder_pd_position_controller_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // predictor state: mirrors the block's registers and counters
  logic [GAIN_W-1:0]       kp_gain;
  logic [GAIN_W-1:0]       kd_gain;
  logic [LIM_W-1:0]        drive_lim;
  logic signed [POS_W-1:0] pos_count;
  logic signed [ERR_W-1:0] prev_err;

  // words waiting to be sent and drive results waiting to arrive
  enc_word_t pending_words[$];
  drive_t    expected_drives[$];

  // position as the stimulus will leave it, used to aim targets near it
  logic signed [POS_W-1:0] plan_pos;

  int unsigned fail_cnt;
  int unsigned quiet_cycles;

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Predictor: one tick word gives the drive it should produce
  // --------------------------------------------------------------------------
  function automatic drive_t predict_drive(input logic signed [POS_W-1:0] target);
    drive_t                  r;
    logic signed [ERR_W-1:0] err;
    logic signed [ERR_W:0]   diff;
    longint                  sum;
    longint                  mag;
    // error and its change are exact: sign-extend before subtracting
    err  = {target[POS_W-1], target} - {pos_count[POS_W-1], pos_count};
    diff = {err[ERR_W-1], err} - {prev_err[ERR_W-1], prev_err};
    sum  = longint'(kp_gain) * longint'(err) + longint'(kd_gain) * longint'(diff);
    // truncate the magnitude so the drive rounds toward zero
    mag = (sum < 0) ? -sum : sum;
    mag = mag >> GAIN_FRAC_BITS;
    if (mag > longint'(drive_lim)) begin
      mag = longint'(drive_lim);
    end
    // a drive that rounds to zero counts as forward
    r.direction    = (sum < 0) && (mag != 0);
    r.pwm_duty     = mag[LIM_W-1:0];
    r.position_now = pos_count;
    r.error_now    = err;
    prev_err       = err;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: bursts of words with random gaps in between
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_n) begin : word_driver
    enc_word_t   w;
    int unsigned burst_left;
    int unsigned gap_left;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      burst_left = $urandom_range(1, 40);
      gap_left   = 0;
    end else begin
      // fold every accepted word into the predictor
      if (in_if.valid && in_if.ready) begin
        if (in_if.func == FUNC_EDGE) begin
          pos_count = in_if.channel_b_level ? pos_count - 1 : pos_count + 1;
        end else begin
          expected_drives.push_back(predict_drive(in_if.target_count));
        end
      end
      // hold the bus while a word is still on offer
      if (!in_if.valid || in_if.ready) begin
        if (gap_left != 0) begin
          in_if.valid <= 1'b0;
          gap_left--;
        end else if (pending_words.size() != 0) begin
          w = pending_words.pop_front();
          in_if.valid           <= 1'b1;
          in_if.func            <= w.func;
          in_if.channel_b_level <= w.channel_b_level;
          in_if.target_count    <= w.target_count;
          if (burst_left <= 1) begin
            // one burst in four runs straight into the next
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 60);
          end else begin
            burst_left--;
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: check each word, then pick the next ready level
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_n) begin : drive_monitor
    drive_t      want;
    rx_mode_e    rx_mode;
    int unsigned rx_left;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      rx_mode = RX_OPEN;
      rx_left = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_drives.size() == 0) begin
          $error("result word with no tick waiting for it");
          fail_cnt++;
        end else begin
          want = expected_drives.pop_front();
          if (out_if.direction !== want.direction) begin
            $error("direction: expected %0d, got %0d", want.direction, out_if.direction);
            fail_cnt++;
          end
          if (out_if.pwm_duty !== want.pwm_duty) begin
            $error("pwm_duty: expected %0d, got %0d", want.pwm_duty, out_if.pwm_duty);
            fail_cnt++;
          end
          if (out_if.position_now !== want.position_now) begin
            $error("position_now: expected %0d, got %0d",
                   want.position_now, out_if.position_now);
            fail_cnt++;
          end
          if (out_if.error_now !== want.error_now) begin
            $error("error_now: expected %0d, got %0d", want.error_now, out_if.error_now);
            fail_cnt++;
          end
        end
      end
      // switch to a new random style and run length once rx_left runs out
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(50, 300);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        RX_OPEN:  out_if.ready <= 1'b1;
        RX_LIGHT: out_if.ready <= ($urandom_range(0, 3) != 0);
        RX_HALF:  out_if.ready <= ($urandom_range(0, 1) != 0);
        default:  out_if.ready <= ($urandom_range(0, 9) < 2);
      endcase
    end
  end

  // count cycles in which neither channel moves a word
  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("FAILURE");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // queue an edge; target_count rides along with junk that must be ignored
  task automatic queue_edge(input logic b_level);
    enc_word_t w;
    w.func            = FUNC_EDGE;
    w.channel_b_level = b_level;
    w.target_count    = $urandom();
    pending_words.push_back(w);
    plan_pos = b_level ? plan_pos - 1 : plan_pos + 1;
  endtask

  // queue a tick; channel_b_level is random and must be ignored
  task automatic queue_tick(input logic signed [POS_W-1:0] target);
    enc_word_t w;
    w.func            = FUNC_TICK;
    w.channel_b_level = $urandom_range(0, 1);
    w.target_count    = target;
    pending_words.push_back(w);
  endtask

  // wait until every word is sent and every drive checked, then let the
  // pipeline empty of trailing edge words
  task automatic wait_idle();
    while (pending_words.size() != 0 || in_if.valid || expected_drives.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // write all three registers and one dead index, one write per cycle
  task automatic set_gains(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] kd,
                           input logic [LIM_W-1:0] lim);
    logic [CFG_IDX_W-1:0]  idx_list[4];
    logic [CFG_DATA_W-1:0] data_list[4];
    idx_list  = '{REG_UNUSED_IDX, REG_KP_GAIN, REG_KD_GAIN, REG_DRIVE_LIMIT};
    data_list = '{CFG_DATA_W'($urandom()), kp, kd, CFG_DATA_W'(lim)};
    foreach (idx_list[i]) begin
      @(posedge clk_i);
      cfg_we   <= 1'b1;
      cfg_idx  <= idx_list[i];
      cfg_data <= data_list[i];
      case (idx_list[i])
        REG_KP_GAIN:     kp_gain   = data_list[i];
        REG_KD_GAIN:     kd_gain   = data_list[i];
        REG_DRIVE_LIMIT: drive_lim = data_list[i][LIM_W-1:0];
        default: ;
      endcase
    end
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // mostly edges and ticks aimed near the position, with some wild targets
  task automatic queue_random_words(input int unsigned n_words);
    int unsigned sent;
    int unsigned roll;
    int unsigned run;
    int          offset;
    logic        drift;
    sent  = 0;
    drift = $urandom_range(0, 1);
    while (sent < n_words) begin
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
        // a short run of edges, mostly in one direction
        run = $urandom_range(1, 8);
        repeat (run) begin
          queue_edge(($urandom_range(0, 3) == 0) ? ~drift : drift);
        end
        sent += run;
        if ($urandom_range(0, 7) == 0) drift = ~drift;
      end else begin
        if (roll < 78) begin
          offset = int'($urandom_range(0, 800)) - 400;
          queue_tick(plan_pos + offset);
        end else if (roll < 88) begin
          queue_tick($urandom());
        end else if (roll < 93) begin
          offset = int'($urandom_range(0, 6)) - 3;
          queue_tick(plan_pos + offset);
        end else begin
          case ($urandom_range(0, 2))
            0:       queue_tick(32'sh7FFF_FFFF);
            1:       queue_tick(32'sh8000_0000);
            default: queue_tick(plan_pos);
          endcase
        end
        sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    clk_i                  = 1'b0;
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_idx                = REG_KP_GAIN;
    cfg_data               = '0;
    in_if.valid            = 1'b0;
    in_if.func             = FUNC_EDGE;
    in_if.channel_b_level  = 1'b0;
    in_if.target_count     = '0;
    out_if.ready           = 1'b0;
    fail_cnt               = 0;
    quiet_cycles           = 0;
    // predictor starts from the reset defaults
    kp_gain   = KP_GAIN_RST;
    kd_gain   = KD_GAIN_RST;
    drive_lim = DRIVE_LIMIT_RST;
    pos_count = '0;
    prev_err  = '0;
    plan_pos  = '0;

    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;

    // directed words under the reset gains
    queue_tick(32'sd0);                 // zero error, zero drive
    queue_tick(32'sh7FFF_FFFF);         // largest target: saturate forward
    queue_tick(32'sh8000_0000);         // smallest target: saturate reverse
    queue_edge(1'b0);                   // count up on B low
    queue_edge(1'b0);
    queue_edge(1'b0);
    queue_edge(1'b1);                   // count down on B high
    queue_tick(plan_pos - 1);           // huge positive change term
    queue_tick(plan_pos - 1);           // small negative drive truncates to zero
    queue_tick(plan_pos + 1);
    queue_tick(plan_pos + 1);           // small positive drive truncates to zero
    queue_tick(plan_pos + 100);
    queue_tick(plan_pos - 100);         // moderate reverse, below the limit
    queue_edge(1'b1);
    queue_edge(1'b1);
    queue_edge(1'b1);
    queue_edge(1'b1);                   // cross below zero
    queue_tick(32'sh0000_0001);
    queue_tick(-32'sd1);
    queue_tick(plan_pos);
    wait_idle();

    // extremes first, then random settings
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       set_gains(16'hFFFF, 16'hFFFF, 8'hFF);
        1:       set_gains(16'h0000, 16'h0000, 8'h00);
        2:       set_gains(16'hFFFF, 16'h0000, 8'h01);
        3:       set_gains(16'h0000, 16'hFFFF, 8'h80);
        4:       set_gains(16'hFFFF, 16'hFFFF, 8'h00);
        default: set_gains(GAIN_W'($urandom_range(0, 65535)),
                           GAIN_W'($urandom_range(0, 65535)),
                           LIM_W'($urandom_range(0, 255)));
      endcase
      queue_random_words(PHASE_WORDS);
      wait_idle();
    end

    // finish under random gains once more, then close out
    set_gains(GAIN_W'($urandom_range(0, 65535)), GAIN_W'($urandom_range(0, 65535)),
              LIM_W'($urandom_range(0, 255)));
    queue_random_words(PHASE_WORDS / 2);
    wait_idle();

    if (expected_drives.size() != 0) begin
      $error("%0d drive results never arrived", expected_drives.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pdpc_pkg.sv
rtl/pdpc_stream_if.sv
rtl/encoder_pd_position_controller_top.sv
bench/tb_top.sv
